// ----- rtl/lst_pkg.sv -----
`default_nettype none

package lst_pkg;

  // APB register map
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_MAX_STRIDE = 2'd0;
  localparam logic [1:0] REG_ENABLE     = 2'd1;
  localparam logic [1:0] REG_WARMUP     = 2'd2;

  // Event codes on the result channel
  localparam logic [2:0] EV_ALLOC     = 3'd0;
  localparam logic [2:0] EV_SET       = 3'd1;
  localparam logic [2:0] EV_OVER_MAX  = 3'd2;
  localparam logic [2:0] EV_CHANGED   = 3'd3;
  localparam logic [2:0] EV_CONFIRMED = 3'd4;

  // Confidence levels
  localparam logic [1:0] CONF_NONE      = 2'd0;
  localparam logic [1:0] CONF_SEEN      = 2'd1;
  localparam logic [1:0] CONF_CONFIRMED = 2'd2;

  typedef struct packed {
    logic [63:0] load_pc;
    logic [63:0] load_addr;
    logic [31:0] cycle;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] stride_out;
    logic [1:0]         confidence_out;
    logic [2:0]         event_res;
  } result_t;

  typedef struct packed {
    logic [63:0] tag_pc;
    logic [63:0] prev_addr;
    logic [31:0] stride;
    logic [1:0]  conf;
    logic [31:0] alloc_stamp;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] max_stride;
    logic               enable;
    logic [31:0]        warmup_cycle;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/lst_cfg.sv -----
`default_nettype none

module lst_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lst_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lst_pkg::DATA_W-1:0]  pwdata,
  output logic      [lst_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output lst_pkg::cfg_t                    cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_stride   <= -32'sd1;
      cfg.enable       <= 1'b1;
      cfg.warmup_cycle <= '0;
    end else if (wr) begin
      unique case (idx)
        lst_pkg::REG_MAX_STRIDE: cfg.max_stride   <= pwdata;
        lst_pkg::REG_ENABLE:     cfg.enable       <= pwdata[0];
        lst_pkg::REG_WARMUP:     cfg.warmup_cycle <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lst_pkg::REG_MAX_STRIDE: prdata = cfg.max_stride;
      lst_pkg::REG_ENABLE:     prdata = {31'd0, cfg.enable};
      lst_pkg::REG_WARMUP:     prdata = cfg.warmup_cycle;
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lst_set_index.sv -----
`default_nettype none

// pc mod NUM_SETS over six registered steps: fold the PC in 16-bit chunks
// against 2^(16k) mod N, then an exact reciprocal divide and subtract.
module lst_set_index #(
  parameter int NUM_SETS = 64,
  localparam int SW      = $clog2(NUM_SETS),
  localparam int SET_IW  = (SW > 0) ? SW : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire lst_pkg::item_t      in_item,
  output logic                     out_valid,
  output lst_pkg::item_t           out_item,
  output logic [SET_IW-1:0]        out_set
);

  localparam int PROD_W = 16 + SET_IW;
  localparam int V_W    = PROD_W + 2;
  localparam int SHIFT  = V_W + SW;
  localparam int MW     = SHIFT + 1;
  localparam int LO_W   = (MW + 1) / 2;
  localparam int HI_W   = MW - LO_W;
  localparam int NUM_W  = SW + 1;

  localparam int unsigned R0 = 1 % NUM_SETS;
  localparam int unsigned R1 = 65536 % NUM_SETS;
  localparam int unsigned R2 = (R1 * R1) % NUM_SETS;
  localparam int unsigned R3 = (R2 * R1) % NUM_SETS;

  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
  localparam logic [MW-1:0]   RECIP    = RECIP64[MW-1:0];
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[MW-1:LO_W];

  logic                    s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  lst_pkg::item_t          s1_item, s2_item, s3_item, s4_item, s5_item;
  logic [PROD_W-1:0]       s1_p0, s1_p1, s1_p2, s1_p3;
  logic [V_W-1:0]          s2_v, s3_v, s4_v, s5_v;
  logic [V_W+LO_W-1:0]     s3_pl;
  logic [V_W+HI_W-1:0]     s3_ph;
  logic [V_W-1:0]          s4_q;
  logic [V_W-1:0]          s5_qn;

  logic [V_W+MW-1:0]       full;
  logic [V_W+NUM_W-1:0]    qn_full;
  logic [V_W-1:0]          rem;

  assign full    = {s3_ph, {LO_W{1'b0}}} + (V_W + MW)'(s3_pl);
  assign qn_full = (V_W + NUM_W)'(s4_q) * (V_W + NUM_W)'(NUM_SETS);
  assign rem     = s5_v - s5_qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // chunk products
      s1_item <= in_item;
      s1_p0   <= PROD_W'(in_item.load_pc[15:0])  * PROD_W'(R0);
      s1_p1   <= PROD_W'(in_item.load_pc[31:16]) * PROD_W'(R1);
      s1_p2   <= PROD_W'(in_item.load_pc[47:32]) * PROD_W'(R2);
      s1_p3   <= PROD_W'(in_item.load_pc[63:48]) * PROD_W'(R3);
      // folded value, congruent to pc mod N
      s2_item <= s1_item;
      s2_v    <= V_W'(s1_p0) + V_W'(s1_p1) + V_W'(s1_p2) + V_W'(s1_p3);
      // reciprocal partial products
      s3_item <= s2_item;
      s3_v    <= s2_v;
      s3_pl   <= (V_W + LO_W)'(s2_v) * (V_W + LO_W)'(RECIP_LO);
      s3_ph   <= (V_W + HI_W)'(s2_v) * (V_W + HI_W)'(RECIP_HI);
      // quotient
      s4_item <= s3_item;
      s4_v    <= s3_v;
      s4_q    <= full[SHIFT +: V_W];
      // q * N never exceeds v
      s5_item <= s4_item;
      s5_v    <= s4_v;
      s5_qn   <= qn_full[V_W-1:0];
      out_item <= s5_item;
      out_set  <= rem[SET_IW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lst_way_mem.sv -----
`default_nettype none

// One way of the table: one write port, one registered read port with
// write-to-read forwarding when both hit the same set in the same cycle.
module lst_way_mem #(
  parameter int NUM_SETS = 64,
  localparam int SW      = $clog2(NUM_SETS),
  localparam int SET_IW  = (SW > 0) ? SW : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [SET_IW-1:0]    rd_set,
  output lst_pkg::entry_t           rd_data,
  input  wire logic                 wr_en,
  input  wire logic [SET_IW-1:0]    wr_set,
  input  wire lst_pkg::entry_t      wr_data
);

  lst_pkg::entry_t mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_set == rd_set)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_set];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lst_update.sv -----
`default_nettype none

// Lookup and update of one set: tag match, oldest-way victim, stride and
// confidence update, result fields.
module lst_update #(
  parameter int NUM_WAYS = 4,
  localparam int WL      = $clog2(NUM_WAYS),
  localparam int WAY_IW  = (WL > 0) ? WL : 1
) (
  input  wire lst_pkg::item_t   item,
  input  wire lst_pkg::entry_t  entries [NUM_WAYS],
  input  wire lst_pkg::cfg_t    cfg,
  output lst_pkg::result_t      result,
  output logic [WAY_IW-1:0]     wr_way,
  output lst_pkg::entry_t       wr_data
);

  localparam int P = 1 << WL;

  logic                hit;
  logic [WAY_IW-1:0]   hit_way;
  logic [WAY_IW-1:0]   victim;
  lst_pkg::entry_t     e;
  logic [31:0]         ns;
  logic [31:0]         mag;
  logic                over;
  logic [31:0]         stride_next;
  logic [1:0]          conf;
  logic [2:0]          ev;

  logic [31:0]         nd_stamp [P];
  logic [WAY_IW-1:0]   nd_idx   [P];
  logic                nd_ok    [P];

  // first matching way
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (entries[w].tag_pc == item.load_pc) begin
        hit     = 1'b1;
        hit_way = WAY_IW'(w);
      end
    end
  end

  // first way with the smallest stamp; ties keep the lower way
  always_comb begin
    for (int i = 0; i < P; i++) begin
      nd_ok[i]    = 1'b0;
      nd_stamp[i] = '0;
      nd_idx[i]   = WAY_IW'(i);
      if (i < NUM_WAYS) begin
        nd_ok[i]    = 1'b1;
        nd_stamp[i] = entries[i].alloc_stamp;
      end
    end
    for (int l = 0; l < WL; l++) begin
      for (int i = 0; i < (P >> (l + 1)); i++) begin
        if (nd_ok[2*i+1] && (nd_stamp[2*i+1] < nd_stamp[2*i])) begin
          nd_stamp[i] = nd_stamp[2*i+1];
          nd_idx[i]   = nd_idx[2*i+1];
        end else begin
          nd_stamp[i] = nd_stamp[2*i];
          nd_idx[i]   = nd_idx[2*i];
        end
        nd_ok[i] = nd_ok[2*i];
      end
    end
    victim = nd_idx[0];
  end

  assign e    = entries[hit_way];
  assign ns   = item.load_addr[31:0] - e.prev_addr[31:0];
  assign mag  = ns[31] ? (32'd0 - ns) : ns;
  assign over = !cfg.max_stride[31] && (mag > $unsigned(cfg.max_stride));

  always_comb begin
    stride_next = e.stride;
    if (e.conf == lst_pkg::CONF_NONE) begin
      stride_next = ns;
      conf = over ? lst_pkg::CONF_NONE : lst_pkg::CONF_SEEN;
      ev   = over ? lst_pkg::EV_OVER_MAX : lst_pkg::EV_SET;
    end else if (ns != e.stride) begin
      stride_next = ns;
      conf = over ? lst_pkg::CONF_NONE : lst_pkg::CONF_SEEN;
      ev   = over ? lst_pkg::EV_OVER_MAX : lst_pkg::EV_CHANGED;
    end else begin
      conf = lst_pkg::CONF_CONFIRMED;
      ev   = lst_pkg::EV_CONFIRMED;
    end
    if (!cfg.enable || (item.cycle < cfg.warmup_cycle)) begin
      conf = lst_pkg::CONF_NONE;
    end
  end

  always_comb begin
    if (hit) begin
      wr_way                 = hit_way;
      wr_data                = e;
      wr_data.prev_addr      = item.load_addr;
      wr_data.stride         = stride_next;
      wr_data.conf           = conf;
      result.hit             = 1'b1;
      result.stride_out      = stride_next;
      result.confidence_out  = conf;
      result.event_res       = ev;
    end else begin
      wr_way                 = victim;
      wr_data.tag_pc         = item.load_pc;
      wr_data.prev_addr      = item.load_addr;
      wr_data.stride         = '0;
      wr_data.conf           = lst_pkg::CONF_NONE;
      wr_data.alloc_stamp    = item.cycle;
      result.hit             = 1'b0;
      result.stride_out      = '0;
      result.confidence_out  = lst_pkg::CONF_NONE;
      result.event_res       = lst_pkg::EV_ALLOC;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/load_stride_table_core.sv -----
// Load stride table: a NUM_SETS x NUM_WAYS set-associative table of load PCs
// that tracks the stride of each load and a confidence of 0, 1 or 2.
// Channels: an item transaction (item_valid / item_stall / item) carries
// load_pc, load_addr and cycle; a result transaction (result_valid /
// result_stall / result) carries hit, stride_out, confidence_out, event_res.
// Every item gives exactly one result, in order.
// Throughput: one item per cycle while nothing stalls. The set index
// (pc mod NUM_SETS) takes six registered steps, the first loaded at the
// edge that takes the item; the table read adds one and the update and
// result register one more.
// The pipeline moves as one: while result_stall holds a waiting result the
// whole pipeline freezes and item_stall is raised; nothing is dropped.
// Reset: rst clears the pipeline and starts a clearing pass that zeroes
// the table one set per cycle; item_stall stays high until the pass ends.
// Registers on the APB port are taken at any time, but
// should only be changed while no item is in flight.
// Registers: 0x0 max_stride (reset -1, negative disables the check),
// 0x4 enable (reset 1), 0x8 warmup_cycle (reset 0).
`default_nettype none

module load_stride_table_core #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire lst_pkg::item_t              item,
  // result channel
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output lst_pkg::result_t                 result,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lst_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lst_pkg::DATA_W-1:0]  pwdata,
  output logic      [lst_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int SW     = $clog2(NUM_SETS);
  localparam int SET_IW = (SW > 0) ? SW : 1;
  localparam int WL     = $clog2(NUM_WAYS);
  localparam int WAY_IW = (WL > 0) ? WL : 1;

  lst_pkg::cfg_t      cfg;

  // pipeline advance: frozen only while a finished result waits
  logic               adv;

  // clearing pass after reset
  logic               clearing;
  logic [SET_IW-1:0]  clr_set;

  // set index pipeline output
  logic               idx_valid;
  lst_pkg::item_t     idx_item;
  logic [SET_IW-1:0]  idx_set;

  // update stage
  logic               c_valid;
  lst_pkg::item_t     c_item;
  logic [SET_IW-1:0]  c_set;

  lst_pkg::entry_t    rd_data [NUM_WAYS];
  lst_pkg::result_t   upd_result;
  logic [WAY_IW-1:0]  upd_way;
  lst_pkg::entry_t    upd_data;

  logic [NUM_WAYS-1:0] wr_en;
  logic [SET_IW-1:0]   wr_set;
  lst_pkg::entry_t     wr_data;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = clearing || !adv;

  lst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_set  <= '0;
    end else if (clearing) begin
      if (clr_set == SET_IW'(NUM_SETS - 1)) begin
        clearing <= 1'b0;
      end
      clr_set <= clr_set + SET_IW'(1);
    end
  end

  lst_set_index #(.NUM_SETS(NUM_SETS)) u_index (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (item_valid && !clearing),
    .in_item   (item),
    .out_valid (idx_valid),
    .out_item  (idx_item),
    .out_set   (idx_set)
  );

  // Table write: the clearing pass zeroes every way of a set, otherwise the
  // item in the update stage writes its hit way or its victim as it leaves.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      wr_en[w] = clearing || (c_valid && adv && (upd_way == WAY_IW'(w)));
    end
    wr_set  = clearing ? clr_set : c_set;
    wr_data = clearing ? '0 : upd_data;
  end

  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_way
    lst_way_mem #(.NUM_SETS(NUM_SETS)) u_mem (
      .clk     (clk),
      .rd_en   (adv),
      .rd_set  (idx_set),
      .rd_data (rd_data[g]),
      .wr_en   (wr_en[g]),
      .wr_set  (wr_set),
      .wr_data (wr_data)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= idx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_item <= idx_item;
      c_set  <= idx_set;
    end
  end

  lst_update #(.NUM_WAYS(NUM_WAYS)) u_update (
    .item    (c_item),
    .entries (rd_data),
    .cfg     (cfg),
    .result  (upd_result),
    .wr_way  (upd_way),
    .wr_data (upd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= upd_result;
    end
  end

  // no item can reach the table while it is being cleared
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !c_valid && !idx_valid)
    else $error("item in flight during clearing pass");

  // a normal update writes at most one way
  a_one_way_write: assert property (@(posedge clk) disable iff (rst)
    !clearing |-> $onehot0(wr_en))
    else $error("more than one way written");

  // a miss reports an allocation with cleared stride and confidence
  a_miss_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |->
      result.stride_out == 32'sd0 &&
      result.confidence_out == lst_pkg::CONF_NONE &&
      result.event_res == lst_pkg::EV_ALLOC)
    else $error("miss result not an allocation");

  // confidence 3 never leaves the block
  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.confidence_out != 2'd3)
    else $error("confidence out of range");

endmodule

`default_nettype wire

// ----- verif/load_stride_table_checker.sv -----
`default_nettype none

module load_stride_table_checker #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire logic                       item_stall,
  input  wire lst_pkg::item_t             item,
  input  wire logic                       result_valid,
  input  wire logic                       result_stall,
  input  wire lst_pkg::result_t           result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lst_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lst_pkg::DATA_W-1:0] pwdata,
  input  wire logic                       pready,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import lst_pkg::*;

  localparam int ENTRIES = NUM_SETS * NUM_WAYS;

  // shadow table and registers
  logic [63:0] tag_q    [ENTRIES];
  logic [63:0] prev_q   [ENTRIES];
  logic [31:0] stride_q [ENTRIES];
  logic [1:0]  conf_q   [ENTRIES];
  logic [31:0] stamp_q  [ENTRIES];

  logic [31:0] max_stride_q;
  logic        enable_q;
  logic [31:0] warmup_q;

  result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // negative limit switches the check off; |0x80000000| is 2^31
  function automatic logic stride_too_big(logic [31:0] s);
    logic [31:0] mag;
    if (max_stride_q[31])
      return 1'b0;
    mag = s[31] ? -s : s;
    return mag > max_stride_q;
  endfunction

  task automatic predict_stride(input item_t it, output result_t r);
    int          base;
    int          e;
    int          victim;
    logic        found;
    logic [31:0] ns;
    logic [1:0]  conf;
    logic [2:0]  ev;
    base  = int'(it.load_pc % NUM_SETS) * NUM_WAYS;
    e     = base;
    found = 1'b0;
    r     = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && tag_q[base+w] == it.load_pc) begin
        e     = base + w;
        found = 1'b1;
      end
    end
    if (!found) begin
      // first way with the oldest stamp goes
      victim = base;
      for (int w = 1; w < NUM_WAYS; w++) begin
        if (stamp_q[base+w] < stamp_q[victim])
          victim = base + w;
      end
      tag_q[victim]    = it.load_pc;
      prev_q[victim]   = it.load_addr;
      stride_q[victim] = '0;
      conf_q[victim]   = CONF_NONE;
      stamp_q[victim]  = it.cycle;
      r.event_res      = EV_ALLOC;
    end else begin
      ns = it.load_addr[31:0] - prev_q[e][31:0];
      if (conf_q[e] == CONF_NONE) begin
        stride_q[e] = ns;
        if (stride_too_big(ns)) begin
          conf = CONF_NONE;
          ev   = EV_OVER_MAX;
        end else begin
          conf = CONF_SEEN;
          ev   = EV_SET;
        end
      end else if (ns != stride_q[e]) begin
        stride_q[e] = ns;
        if (stride_too_big(ns)) begin
          conf = CONF_NONE;
          ev   = EV_OVER_MAX;
        end else begin
          conf = CONF_SEEN;
          ev   = EV_CHANGED;
        end
      end else begin
        conf = CONF_CONFIRMED;
        ev   = EV_CONFIRMED;
      end
      if (!enable_q)
        conf = CONF_NONE;
      if (warmup_q > it.cycle)
        conf = CONF_NONE;
      conf_q[e]          = conf;
      prev_q[e]          = it.load_addr;
      r.hit              = 1'b1;
      r.stride_out       = stride_q[e];
      r.confidence_out   = conf;
      r.event_res        = ev;
    end
  endtask

  task automatic cmp_field(string fld, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: result %0d field %s: expected 0x%0h, actual 0x%0h",
               $time, checked, fld, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_q[i]    = '0;
        prev_q[i]   = '0;
        stride_q[i] = '0;
        conf_q[i]   = CONF_NONE;
        stamp_q[i]  = '0;
      end
      max_stride_q = '1;
      enable_q     = 1'b1;
      warmup_q     = '0;
      expected_results.delete();
    end else begin
      // results leave before this edge's item can add one
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected: hit %0b stride 0x%0h",
                   $time, result.hit, result.stride_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          cmp_field("hit", want.hit, result.hit);
          cmp_field("stride_out", want.stride_out, result.stride_out);
          cmp_field("confidence_out", want.confidence_out, result.confidence_out);
          cmp_field("event_res", want.event_res, result.event_res);
          checked++;
        end
      end
      if (item_valid && !item_stall) begin
        predict_stride(item, want);
        expected_results.push_back(want);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MAX_STRIDE: max_stride_q = pwdata;
          REG_ENABLE:     enable_q     = pwdata[0];
          REG_WARMUP:     warmup_q     = pwdata;
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

// ----- verif/load_stride_table_core_tb.sv -----
`default_nettype none

module load_stride_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lst_pkg::*;

  localparam int NUM_SETS    = 64;
  localparam int NUM_WAYS    = 4;
  // eight pipeline stages from item to result, plus margin
  localparam int LATENCY     = 8;
  localparam int SETTLE      = LATENCY + 4;
  // generous bound: clearing pass, ~950 transactions at worst-case stall rates
  localparam int LIMIT       = 300000;
  localparam int NSTREAM     = 20;
  localparam int NPHASES     = 8;
  localparam int PHASE_ITEMS = 116;
  localparam int HOLD_CYCLES = 80;
  // streams crowd into a handful of sets so that ways get evicted
  localparam logic [5:0] HOT_SET  = 6'd8;
  localparam int         HOT_SPAN = 5;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                result_valid;
  logic                result_stall;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int fail_total;
  int in_flight;
  int results_checked;

  // stimulus bookkeeping
  int          cycles;
  int          items_sent;
  int          directed_items;
  int          reg_writes;
  int          idle_pct;
  int          stall_pct;
  logic        hold_req;
  logic [31:0] cyc_now;

  // per-stream state: a load PC walking through memory with a stride
  logic [63:0] s_pc     [NSTREAM];
  logic [63:0] s_addr   [NSTREAM];
  logic [31:0] s_stride [NSTREAM];

  load_stride_table_core #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Predicts every item transaction and checks every result transaction
  load_stride_table_checker #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_total),
    .pending      (in_flight),
    .checked      (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: counts clock cycles, gives up at LIMIT.
  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycles, in_flight);
    $display("FAILURE");
    $finish;
  end

  // Receiver side. Stalls at random at stall_pct; a hold request from the
  // stimulus turns into a long, cycle-counted hold-off so the pipeline fills
  // and back-pressures the item channel.
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    hold_req     = 1'b0;
    stall_pct    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic [63:0] sext(logic [31:0] s);
    return {{32{s[31]}}, s};
  endfunction

  // Mix of small, medium and full-range strides, plus the most negative one
  function automatic logic [31:0] pick_stride();
    logic [31:0] mag;
    case ($urandom_range(9))
      0:       mag = 32'h8000_0000;
      1, 2:    mag = $urandom;
      3, 4, 5: mag = $urandom_range(5000);
      default: mag = $urandom_range(300);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic logic [63:0] hot_pc();
    logic [63:0] pc;
    pc      = {$urandom, $urandom};
    pc[5:0] = HOT_SET + 6'($urandom_range(HOT_SPAN-1));
    return pc;
  endfunction

  // One item transaction. Entered and left at a falling edge. valid is left
  // high when no gap follows, so back-to-back items never drop it; whoever
  // stops sending lowers it.
  task automatic send_item(input item_t it);
    int gap;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send(input logic [63:0] pc, input logic [63:0] addr, input logic [31:0] cyc);
    item_t it;
    it.load_pc   = pc;
    it.load_addr = addr;
    it.cycle     = cyc;
    send_item(it);
  endtask

  // Stop offering items and wait until every expected result has come back,
  // then let the pipeline settle.
  task automatic drain_pipeline();
    item_valid <= 1'b0;
    while (in_flight != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Setup cycle, access cycle, then an idle cycle so that back-to-back
  // writes never touch psel twice in one step.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  // Registers change only with the table idle.
  task automatic reconfigure(input logic [31:0] mx, input logic en, input logic [31:0] wu);
    drain_pipeline();
    apb_write(REG_MAX_STRIDE, mx);
    apb_write(REG_ENABLE, {31'b0, en});
    apb_write(REG_WARMUP, wu);
  endtask

  // Random traffic: mostly well-behaved strided streams so that entries
  // climb to confirmed, with stride changes, address jumps, stream
  // re-seeds (new PCs, evictions) and some pure noise.
  task automatic send_random_item();
    item_t it;
    int    k;
    int    r;
    k        = $urandom_range(NSTREAM-1);
    r        = $urandom_range(99);
    cyc_now  = cyc_now + $urandom_range(3);
    it.cycle = cyc_now;
    if (r < 8) begin
      it.load_pc   = {$urandom, $urandom};
      it.load_addr = {$urandom, $urandom};
      if ($urandom_range(3) == 0)
        it.cycle = $urandom;
    end else begin
      if (r < 12)
        s_pc[k] = hot_pc();
      else if (r < 24)
        s_stride[k] = pick_stride();
      if (r >= 24 && r < 30)
        s_addr[k] = {$urandom, $urandom};
      else
        s_addr[k] = s_addr[k] + sext(s_stride[k]);
      it.load_pc   = s_pc[k];
      it.load_addr = s_addr[k];
    end
    send_item(it);
  endtask

  initial begin : stimulus
    logic [63:0] pc;
    logic [63:0] addr;
    logic [31:0] mx;
    logic        en;
    logic [31:0] wu;

    // everything known from time zero
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 0;
    items_sent = 0;
    reg_writes = 0;
    cyc_now    = '0;
    for (int k = 0; k < NSTREAM; k++) begin
      s_pc[k]     = hot_pc();
      s_addr[k]   = {$urandom, $urandom};
      s_stride[k] = pick_stride();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // item_stall covers the clearing pass; send_item just waits on it

    // ---- directed: reset register values ----
    // PC 0 hits the untouched zero-tag way: set, confirmed, changed
    send(64'h0, 64'h100, 32'd5);
    send(64'h0, 64'h200, 32'd6);
    send(64'h0, 64'h180, 32'd7);
    // field extremes: all-ones miss, then a wrap-around stride of 1, then the same stride again
    send('1, '1, '1);
    send('1, 64'h0, '1);
    send('1, 64'h1, 32'd0);

    // ---- directed: stride limit of 100 ----
    reconfigure(32'd100, 1'b1, 32'd0);
    pc   = 64'h1234_0000_0000_0081;
    addr = 64'h1000;
    send(pc, addr, 32'd20);                       // allocate
    addr = addr + 64'h8000_0000;
    send(pc, addr, 32'd21);                       // most negative stride, over the limit
    addr = addr + 64'h10;
    send(pc, addr, 32'd22);                       // stride set
    addr = addr + 64'h10;
    send(pc, addr, 32'd23);                       // confirmed
    addr = addr + 64'h1000;
    send(pc, addr, 32'd24);                       // changed and over: over-max wins
    addr = addr + 64'd100;
    send(pc, addr, 32'd25);                       // exactly at the limit is allowed
    addr = addr - 64'd100;
    send(pc, addr, 32'd26);                       // changed to -100

    // ---- directed: warm-up boundary ----
    reconfigure('1, 1'b1, 32'd1000);
    addr = addr - 64'd100;
    send(pc, addr, 32'd999);                      // confirmed but forced to zero
    addr = addr - 64'd100;
    send(pc, addr, 32'd1000);                     // warm-up over

    // ---- directed: table disabled ----
    reconfigure('1, 1'b0, 32'd0);
    addr = addr - 64'd100;
    send(pc, addr, 32'd1001);
    addr = addr - 64'd100;
    send(pc, addr, 32'd1002);

    // ---- directed: victim choice on a tie of oldest stamps ----
    reconfigure('1, 1'b1, 32'd0);
    send(64'hA000_0000_0000_0082, 64'h10, 32'd50);
    send(64'hA100_0000_0000_0082, 64'h20, 32'd30);
    send(64'hA200_0000_0000_0082, 64'h30, 32'd30);
    send(64'hA300_0000_0000_0082, 64'h40, 32'd70);
    send(64'hA400_0000_0000_0082, 64'h50, 32'd80); // first stamp-30 way goes
    send(64'hA000_0000_0000_0082, 64'h18, 32'd81); // survivor still hits
    directed_items = items_sent;

    // ---- random phases, each with its own registers and idling ----
    cyc_now = 32'd2000;
    for (int p = 0; p < NPHASES; p++) begin
      en = 1'b1;
      wu = '0;
      case (p)
        0: mx = '1;
        1: mx = 32'd0;
        2: mx = 32'd256;
        3: mx = 32'h7FFF_FFFF;
        4: begin
          mx = 32'd4096;
          en = 1'b0;
        end
        5: begin
          mx = $urandom_range(1, 1 << 20);
          wu = cyc_now + 32'd150;                 // crossed part-way through
        end
        6: begin
          mx = '1;
          wu = '1;
        end
        default: mx = 32'd1024;
      endcase
      reconfigure(mx, en, wu);
      // idling per phase: none, sender, receiver, both lightly
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct  = 12;
          stall_pct = 12;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 40)
          hold_req = 1'b1;                        // long receiver hold-off
        if (p == 7 && n == PHASE_ITEMS / 2)
          drain_pipeline();                       // sender pause until all is back
        send_random_item();
      end
    end

    // ---- wind down ----
    stall_pct = 0;
    drain_pipeline();

    $display("Covered %0d item transactions (%0d directed), %0d phases, %0d register writes",
             items_sent, directed_items, NPHASES, reg_writes);
    $display("%0d result transactions checked, %0d mismatches, %0d outstanding",
             results_checked, fail_total, in_flight);
    if (fail_total == 0 && in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- load_stride_table_core.f -----
rtl/lst_pkg.sv
rtl/lst_cfg.sv
rtl/lst_set_index.sv
rtl/lst_way_mem.sv
rtl/lst_update.sv
rtl/load_stride_table_core.sv
verif/load_stride_table_checker.sv
verif/load_stride_table_core_tb.sv
